>>> sv/cidt_pkg.sv
package cidt_pkg;

   // Field widths fixed by the transaction format
   localparam int OP_W      = 3;
   localparam int BUS_W     = 2;
   localparam int FRAME_W   = 32;
   localparam int IDENT_W   = 29;
   localparam int TAG_W     = 8;
   localparam int COUNT_W   = 6;
   localparam int PAYLOAD_W = 64;
   localparam int LEN_W     = 4;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 5;
   localparam int ACT_W     = 3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_REG    = 3'd1;
   localparam logic [OP_W-1:0] OP_UNREG  = 3'd2;
   localparam logic [OP_W-1:0] OP_RECV   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;
   localparam logic [OP_W-1:0] OP_LIST   = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_INIT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

   // Actions decided by the front end
   localparam logic [ACT_W-1:0] ACT_ERR   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REG   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_UNREG = 3'd3;
   localparam logic [ACT_W-1:0] ACT_RECV  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_QUERY = 3'd5;
   localparam logic [ACT_W-1:0] ACT_LIST  = 3'd6;

   // Identifier limits
   localparam logic [FRAME_W-1:0] STD_MAX = 32'h0000_07FF;
   localparam logic [FRAME_W-1:0] EXT_MAX = 32'h1FFF_FFFF;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [BUS_W-1:0]     bus;
      logic [FRAME_W-1:0]   frame_id;
      logic                 extended;
      logic [TAG_W-1:0]     handler_tag;
      logic [COUNT_W-1:0]   list_limit;
      logic [PAYLOAD_W-1:0] payload;
      logic [LEN_W-1:0]     length_code;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 hit;
      logic [SLOT_W-1:0]    slot;
      logic [TAG_W-1:0]     handler_out;
      logic [IDENT_W-1:0]   id_out;
      logic                 extended_out;
      logic [PAYLOAD_W-1:0] payload_out;
      logic [LEN_W-1:0]     length_out;
      logic [COUNT_W-1:0]   active_total;
      logic [COUNT_W-1:0]   listed_count;
      logic                 last;
   } rsp_type;

   // Classified command passed from front end to back end
   typedef struct packed {
      logic [ACT_W-1:0]     action;
      logic [STATUS_W-1:0]  err_status;
      logic [BUS_W-1:0]     bus;
      logic [IDENT_W-1:0]   ident;
      logic                 ext;
      logic [TAG_W-1:0]     tag;
      logic [COUNT_W-1:0]   list_limit;
      logic [PAYLOAD_W-1:0] payload;
      logic [LEN_W-1:0]     length_code;
   } cmd_type;

endpackage

>>> sv/cidt_front.sv
module cidt_front
   import cidt_pkg::*;
#(
   parameter int BUS_COUNT = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic init_ff;
   logic init_in;
   logic bus_ok;
   logic id_ok;

   // Parameter checks
   assign bus_ok = ({1'b0, req_data.bus} < 3'(BUS_COUNT));
   assign id_ok  = req_data.extended ? (req_data.frame_id <= EXT_MAX)
                                     : (req_data.frame_id <= STD_MAX);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Table is usable once the first clear has been taken
   assign init_in = init_ff || (q_push && (req_data.op == OP_CLEAR));

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b0;
      end else begin
         init_ff <= init_in;
      end
   end

   // Classify the transaction
   always_comb begin
      q_cmd             = '0;
      q_cmd.bus         = req_data.bus;
      q_cmd.ident       = req_data.frame_id[IDENT_W-1:0];
      q_cmd.ext         = req_data.extended;
      q_cmd.tag         = req_data.handler_tag;
      q_cmd.list_limit  = req_data.list_limit;
      q_cmd.payload     = req_data.payload;
      q_cmd.length_code = req_data.length_code;
      q_cmd.action      = ACT_ERR;
      q_cmd.err_status  = ST_INVALID;
      if (req_data.op == OP_CLEAR) begin
         q_cmd.action = ACT_CLEAR;
      end else if (!init_ff) begin
         q_cmd.err_status = ST_NOT_INIT;
      end else begin
         case (req_data.op)
            OP_REG: begin
               if (id_ok && (req_data.handler_tag != '0) && bus_ok) begin
                  q_cmd.action = ACT_REG;
               end
            end
            OP_UNREG: begin
               if (id_ok && bus_ok) begin
                  q_cmd.action = ACT_UNREG;
               end
            end
            OP_RECV: begin
               // an out-of-range identifier on receive simply misses
               if (bus_ok && !id_ok) begin
                  q_cmd.err_status = ST_NOT_FOUND;
               end else if (bus_ok) begin
                  q_cmd.action = ACT_RECV;
               end
            end
            OP_QUERY: begin
               if (id_ok && bus_ok) begin
                  q_cmd.action = ACT_QUERY;
               end
            end
            OP_LIST: begin
               if (bus_ok) begin
                  q_cmd.action = ACT_LIST;
               end
            end
            default: begin
               q_cmd.err_status = ST_INVALID;
            end
         endcase
      end
   end

endmodule

>>> sv/cidt_queue.sv
module cidt_queue
   import cidt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_data
);

   cmd_type    data_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_pop;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_data  = data_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");
`endif

endmodule

>>> sv/cidt_back.sv
module cidt_back
   import cidt_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SCAN_W = $clog2(ENTRIES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LIST = 2'd2;

   // Table storage; each row owns its comparator
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [IDENT_W-1:0] ident_ff   [ENTRIES];
   logic               ext_ff     [ENTRIES];
   logic [BUS_W-1:0]   bus_ff     [ENTRIES];
   logic [TAG_W-1:0]   handler_ff [ENTRIES];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   cmd_type            cmd_ff;
   cmd_type            cmd_in;
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] match_in;
   logic [SCAN_W-1:0]  scan_ff;
   logic [SCAN_W-1:0]  scan_in;
   logic [COUNT_W-1:0] listed_ff;
   logic [COUNT_W-1:0] listed_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   logic               out_free;
   logic [IDX_W-1:0]   match_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [IDX_W-1:0]   scan_idx;
   logic [IDX_W-1:0]   rd_idx;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic               scan_end;
   logic               scan_hit;
   rsp_type            res;

   // Lowest set bit of a row vector
   function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
      logic [IDX_W-1:0] idx;
      logic             found;
      idx   = '0;
      found = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (v[i] && !found) begin
            idx   = IDX_W'(i);
            found = 1'b1;
         end
      end
      return idx;
   endfunction

   // Row compare against the queue head
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (ident_ff[i] == q_data.ident) &&
                       (ext_ff[i] == q_data.ext) && (bus_ff[i] == q_data.bus);
      end
   end

   assign match_idx = first_set(match_ff);
   assign free_idx  = first_set(~valid_ff);
   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign rd_idx    = (state_ff == S_LIST) ? scan_idx : match_idx;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_end  = (scan_ff == SCAN_W'(ENTRIES)) || (listed_ff == cmd_ff.list_limit);
   assign scan_hit  = valid_ff[scan_idx] && (bus_ff[scan_idx] == cmd_ff.bus);

   // Sequencer: execute one command, or step through the list scan
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      scan_in      = scan_ff;
      listed_in    = listed_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_idx       = free_idx;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      res          = '0;
      res.last     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_data;
               scan_in   = '0;
               listed_in = '0;
               state_in  = (q_data.action == ACT_LIST) ? S_LIST : S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (cmd_ff.action)
                  ACT_CLEAR: begin
                     valid_in   = '0;
                     count_in   = '0;
                     res.status = ST_OK;
                  end
                  ACT_REG: begin
                     if (|match_ff) begin
                        res.status = ST_EXISTS;
                     end else if (&valid_ff) begin
                        res.status = ST_FULL;
                     end else begin
                        wr_en              = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        count_in           = count_ff + COUNT_W'(1);
                        res.status         = ST_OK;
                        res.slot           = SLOT_W'(free_idx);
                        res.handler_out    = cmd_ff.tag;
                        res.id_out         = cmd_ff.ident;
                        res.extended_out   = cmd_ff.ext;
                     end
                  end
                  ACT_UNREG: begin
                     if (!(|match_ff)) begin
                        res.status = ST_NOT_FOUND;
                     end else begin
                        valid_in[match_idx] = 1'b0;
                        count_in            = count_ff - COUNT_W'(1);
                        res.status          = ST_OK;
                        res.slot            = SLOT_W'(match_idx);
                        res.handler_out     = handler_ff[rd_idx];
                        res.id_out          = cmd_ff.ident;
                        res.extended_out    = cmd_ff.ext;
                     end
                  end
                  ACT_RECV, ACT_QUERY: begin
                     if (!(|match_ff)) begin
                        res.status = ST_NOT_FOUND;
                     end else begin
                        res.status       = ST_OK;
                        res.hit          = 1'b1;
                        res.slot         = SLOT_W'(match_idx);
                        res.handler_out  = handler_ff[rd_idx];
                        res.id_out       = cmd_ff.ident;
                        res.extended_out = cmd_ff.ext;
                        if (cmd_ff.action == ACT_RECV) begin
                           res.payload_out = cmd_ff.payload;
                           res.length_out  = cmd_ff.length_code;
                        end
                     end
                  end
                  default: begin
                     res.status = cmd_ff.err_status;
                  end
               endcase
               res.active_total = count_in;
               rsp_valid_in     = 1'b1;
               rsp_data_in      = res;
            end
         end
         S_LIST: begin
            res.active_total = count_ff;
            if (scan_end) begin
               // closing count transaction
               if (out_free) begin
                  res.status       = ST_OK;
                  res.listed_count = listed_ff;
                  rsp_valid_in     = 1'b1;
                  rsp_data_in      = res;
                  state_in         = S_IDLE;
               end
            end else if (scan_hit) begin
               if (out_free) begin
                  res.status       = ST_OK;
                  res.last         = 1'b0;
                  res.slot         = SLOT_W'(scan_idx);
                  res.handler_out  = handler_ff[rd_idx];
                  res.id_out       = ident_ff[rd_idx];
                  res.extended_out = ext_ff[rd_idx];
                  rsp_valid_in     = 1'b1;
                  rsp_data_in      = res;
                  scan_in          = scan_ff + SCAN_W'(1);
                  listed_in        = listed_ff + COUNT_W'(1);
               end
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      match_ff    <= (state_ff == S_IDLE) ? match_in : match_ff;
      scan_ff     <= scan_in;
      listed_ff   <= listed_in;
      rsp_data_ff <= rsp_data_in;
      if (wr_en) begin
         ident_ff[wr_idx]   <= cmd_ff.ident;
         ext_ff[wr_idx]     <= cmd_ff.ext;
         bus_ff[wr_idx]     <= cmd_ff.bus;
         handler_ff[wr_idx] <= cmd_ff.tag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff))
      else $error("active count differs from number of valid rows");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= ENTRIES)
      else $error("active count above table size");

   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> (listed_ff <= cmd_ff.list_limit))
      else $error("list emitted more entries than allowed");
`endif

endmodule

>>> sv/can_id_dispatch_table.sv
// CAN receive dispatch table. Transactions enter a two-deep command queue after
// being checked and classified, so req_ready drops only when the queue is full;
// the execution side then takes one transaction at a time: it pops it and compares
// the identifier against every table row in parallel, then resolves the lowest
// matching or free slot and loads the output register once that is free. A list
// transaction instead walks the table one slot per cycle, waiting at a matching
// slot while the output is occupied, and closes with a count result.
// The table lives in flip-flops with a valid bit per row and needs no clearing
// after reset; send a clear transaction first, as everything else reports not
// initialised until then.
module can_id_dispatch_table
   import cidt_pkg::*;
#(
   parameter int ENTRIES   = 32,
   parameter int BUS_COUNT = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    q_full;
   logic    q_push;
   cmd_type q_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_head;

   // Front end: checks and classification
   cidt_front #(
      .BUS_COUNT (BUS_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // Command queue between the two halves
   cidt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // Back end: table and result generation
   cidt_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import cidt_pkg::*;

   localparam int ENTRIES    = 32;
   localparam int BUS_COUNT  = 2;
   localparam int ITEMS      = 400;
   localparam int STALL_MAX  = 2000;
   localparam int TAIL_WAIT  = 3 * ENTRIES;

   // Op codes the block has no name for; both must be rejected
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   can_id_dispatch_table #(
      .ENTRIES  (ENTRIES),
      .BUS_COUNT(BUS_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the registration table
   logic               slot_live  [ENTRIES];
   logic [IDENT_W-1:0] slot_ident [ENTRIES];
   logic               slot_ext   [ENTRIES];
   logic [BUS_W-1:0]   slot_bus   [ENTRIES];
   logic [TAG_W-1:0]   slot_tag   [ENTRIES];
   int                 live_count = 0;
   logic               table_ready = 1'b0;

   rsp_type awaited_rsps[$];

   // When set, neither side inserts idle cycles
   logic steady = 1'b0;

   int fault_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int hit_count     = 0;
   int full_count    = 0;
   int list_count    = 0;

   function automatic void empty_table();
      for (int k = 0; k < ENTRIES; k++) begin
         slot_live[k]  = 1'b0;
         slot_ident[k] = '0;
         slot_ext[k]   = 1'b0;
         slot_bus[k]   = '0;
         slot_tag[k]   = '0;
      end
      live_count = 0;
   endfunction

   function automatic int find_slot(logic [BUS_W-1:0] bus, logic [FRAME_W-1:0] id,
                                    logic ext);
      for (int k = 0; k < ENTRIES; k++) begin
         if (slot_live[k] && {3'b000, slot_ident[k]} == id && slot_ext[k] == ext &&
             slot_bus[k] == bus)
            return k;
      end
      return -1;
   endfunction

   function automatic void await_rsp(rsp_type r);
      r.active_total = COUNT_W'(live_count);
      awaited_rsps.push_back(r);
   endfunction

   // Works out the results of one accepted transaction and updates the shadow table
   function automatic void predict_dispatch(req_type t);
      rsp_type r;
      logic    bus_ok;
      logic    id_ok;
      int      k;
      int      n;
      r      = '0;
      r.last = 1'b1;
      bus_ok = t.bus < BUS_COUNT;
      id_ok  = t.extended ? (t.frame_id <= EXT_MAX) : (t.frame_id <= STD_MAX);
      if (t.op == OP_CLEAR) begin
         empty_table();
         table_ready = 1'b1;
         r.status = ST_OK;
         await_rsp(r);
         return;
      end
      if (!table_ready) begin
         r.status = ST_NOT_INIT;
         await_rsp(r);
         return;
      end
      case (t.op)
         OP_REG: begin
            if (!id_ok || t.handler_tag == '0 || !bus_ok) begin
               r.status = ST_INVALID;
            end else if (find_slot(t.bus, t.frame_id, t.extended) >= 0) begin
               r.status = ST_EXISTS;
            end else begin
               for (k = 0; k < ENTRIES && slot_live[k]; k++) begin
               end
               if (k >= ENTRIES) begin
                  r.status = ST_FULL;
                  full_count++;
               end else begin
                  slot_live[k]  = 1'b1;
                  slot_ident[k] = t.frame_id[IDENT_W-1:0];
                  slot_ext[k]   = t.extended;
                  slot_bus[k]   = t.bus;
                  slot_tag[k]   = t.handler_tag;
                  live_count++;
                  r.status       = ST_OK;
                  r.slot         = SLOT_W'(k);
                  r.handler_out  = t.handler_tag;
                  r.id_out       = t.frame_id[IDENT_W-1:0];
                  r.extended_out = t.extended;
               end
            end
            await_rsp(r);
         end
         OP_UNREG: begin
            k = find_slot(t.bus, t.frame_id, t.extended);
            if (!id_ok || !bus_ok) begin
               r.status = ST_INVALID;
            end else if (k < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.status       = ST_OK;
               r.slot         = SLOT_W'(k);
               r.handler_out  = slot_tag[k];
               r.id_out       = t.frame_id[IDENT_W-1:0];
               r.extended_out = t.extended;
               slot_live[k]   = 1'b0;
               slot_ident[k]  = '0;
               slot_ext[k]    = 1'b0;
               slot_bus[k]    = '0;
               slot_tag[k]    = '0;
               live_count--;
            end
            await_rsp(r);
         end
         OP_RECV, OP_QUERY: begin
            k = find_slot(t.bus, t.frame_id, t.extended);
            if (!bus_ok || (t.op == OP_QUERY && !id_ok)) begin
               r.status = ST_INVALID;
            end else if (k < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               hit_count++;
               r.status       = ST_OK;
               r.hit          = 1'b1;
               r.slot         = SLOT_W'(k);
               r.handler_out  = slot_tag[k];
               r.id_out       = t.frame_id[IDENT_W-1:0];
               r.extended_out = t.extended;
               if (t.op == OP_RECV) begin
                  r.payload_out = t.payload;
                  r.length_out  = t.length_code;
               end
            end
            await_rsp(r);
         end
         OP_LIST: begin
            if (!bus_ok) begin
               r.status = ST_INVALID;
               await_rsp(r);
            end else begin
               list_count++;
               n = 0;
               for (k = 0; k < ENTRIES && n < t.list_limit; k++) begin
                  if (slot_live[k] && slot_bus[k] == t.bus) begin
                     r              = '0;
                     r.status       = ST_OK;
                     r.slot         = SLOT_W'(k);
                     r.handler_out  = slot_tag[k];
                     r.id_out       = slot_ident[k];
                     r.extended_out = slot_ext[k];
                     r.last         = 1'b0;
                     await_rsp(r);
                     n++;
                  end
               end
               r              = '0;
               r.status       = ST_OK;
               r.listed_count = COUNT_W'(n);
               r.last         = 1'b1;
               await_rsp(r);
            end
         end
         default: begin
            r.status = ST_INVALID;
            await_rsp(r);
         end
      endcase
   endfunction

   // Sends one transaction, with an occasional idle gap first; valid stays high
   // after acceptance until the next falling edge, where it is always redriven
   task automatic send_txn(req_type item);
      int gap;
      gap = (!steady && $urandom_range(0, 99) < 12) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_dispatch(item);
      sent_count++;
   endtask

   // Stops sending and waits until every awaited result has come back
   task automatic drain_rsps();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_txn(logic [OP_W-1:0] op, logic [BUS_W-1:0] bus,
                                        logic [FRAME_W-1:0] id, logic ext,
                                        logic [TAG_W-1:0] tag,
                                        logic [COUNT_W-1:0] maxc,
                                        logic [PAYLOAD_W-1:0] pay,
                                        logic [LEN_W-1:0] len);
      req_type t;
      t.op          = op;
      t.bus         = bus;
      t.frame_id    = id;
      t.extended    = ext;
      t.handler_tag = tag;
      t.list_limit  = maxc;
      t.payload     = pay;
      t.length_code = len;
      return t;
   endfunction

   // Identifiers drawn partly from a small pool so that duplicates and hits occur
   function automatic logic [FRAME_W-1:0] pick_id(logic ext);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40)
         return FRAME_W'($urandom_range(0, 15));
      if (sel < 50)
         return ext ? EXT_MAX : STD_MAX;
      return ext ? ($urandom & EXT_MAX) : FRAME_W'($urandom_range(0, STD_MAX));
   endfunction

   function automatic int pick_live_slot();
      int idx;
      if (live_count == 0)
         return -1;
      idx = $urandom_range(0, live_count - 1);
      for (int k = 0; k < ENTRIES; k++) begin
         if (slot_live[k]) begin
            if (idx == 0)
               return k;
            idx--;
         end
      end
      return -1;
   endfunction

   function automatic logic [OP_W-1:0] OP_ST(int lo, int hi);
      return OP_W'($urandom_range(lo, hi));
   endfunction

   function automatic req_type make_random_txn();
      req_type t;
      int      sel;
      int      aim;
      int      k;
      t = make_txn(OP_RECV, BUS_W'($urandom_range(0, BUS_COUNT - 1)), '0,
                   1'($urandom_range(0, 1)), TAG_W'($urandom_range(1, 255)),
                   COUNT_W'($urandom_range(0, 63)), {$urandom, $urandom},
                   LEN_W'($urandom_range(0, 15)));
      t.frame_id = pick_id(t.extended);
      sel = $urandom_range(0, 99);
      aim = 70;
      if (sel < 32) begin
         t.op = OP_REG;
         aim  = 15;
      end else if (sel < 46) t.op = OP_UNREG;
      else if (sel < 70) t.op = OP_RECV;
      else if (sel < 80) t.op = OP_QUERY;
      else if (sel < 89) t.op = OP_LIST;
      else if (sel < 90) t.op = OP_CLEAR;
      else begin
         // noise: spare op codes, bad bus, wide identifiers, zero handler
         aim = 0;
         case ($urandom_range(0, 4))
            0: t.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
            1: begin
               t.op  = OP_ST(1, 5);
               t.bus = BUS_W'($urandom_range(BUS_COUNT, 3));
            end
            2: begin
               t.op       = OP_ST(1, 4);
               t.frame_id = $urandom;
            end
            3: begin
               t.op          = OP_REG;
               t.handler_tag = '0;
            end
            default: begin
               t.op          = OP_ST(1, 7);
               t.bus         = BUS_W'($urandom_range(0, 3));
               t.frame_id    = $urandom;
               t.handler_tag = TAG_W'($urandom_range(0, 255));
            end
         endcase
      end
      if (t.op != OP_LIST && t.op != OP_CLEAR && $urandom_range(0, 99) < aim) begin
         k = pick_live_slot();
         if (k >= 0) begin
            t.bus      = slot_bus[k];
            t.frame_id = {3'b000, slot_ident[k]};
            t.extended = slot_ext[k];
         end
      end
      return t;
   endfunction

   // Result checker
   function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsps.size() == 0) begin
            $error("result with nothing awaited: %p", rsp_data);
            fault_count++;
         end else begin
            want = awaited_rsps.pop_front();
            field_check("status", want.status, rsp_data.status);
            field_check("hit", want.hit, rsp_data.hit);
            field_check("slot", want.slot, rsp_data.slot);
            field_check("handler_out", want.handler_out, rsp_data.handler_out);
            field_check("id_out", want.id_out, rsp_data.id_out);
            field_check("extended_out", want.extended_out, rsp_data.extended_out);
            field_check("payload_out", want.payload_out, rsp_data.payload_out);
            field_check("length_out", want.length_out, rsp_data.length_out);
            field_check("active_total", want.active_total, rsp_data.active_total);
            field_check("listed_count", want.listed_count, rsp_data.listed_count);
            field_check("last", want.last, rsp_data.last);
            checked_count++;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 12);
   end

   // Watchdog: too long without any transaction accepted on either side
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Every op, including spare codes, before the first clear
   task automatic test_before_clear();
      for (int op = 1; op < 8; op++)
         send_txn(make_txn(OP_W'(op), '0, 32'h5, 1'b0, 8'h11, 6'd4, {$urandom, $urandom},
                           4'd8));
   endtask

   // Field extremes, every op and the invalid, exists and not-found paths on a nearly empty table
   task automatic test_directed();
      send_txn(make_txn(OP_CLEAR, '0, '0, 1'b0, '0, '0, '0, '0));
      send_txn(make_txn(OP_REG, 2'd0, STD_MAX, 1'b0, 8'hFF, '0, '0, '0));
      send_txn(make_txn(OP_REG, 2'd1, EXT_MAX, 1'b1, 8'h01, '0, '0, '0));
      send_txn(make_txn(OP_REG, 2'd0, STD_MAX, 1'b0, 8'h42, '0, '0, '0));     // duplicate
      send_txn(make_txn(OP_REG, 2'd0, STD_MAX, 1'b1, 8'h42, '0, '0, '0));     // other kind
      send_txn(make_txn(OP_REG, 2'd0, STD_MAX + 1, 1'b0, 8'h42, '0, '0, '0)); // too wide
      send_txn(make_txn(OP_REG, 2'd1, EXT_MAX + 1, 1'b1, 8'h42, '0, '0, '0));
      send_txn(make_txn(OP_REG, 2'd0, 32'h0, 1'b0, 8'h00, '0, '0, '0));       // no handler
      send_txn(make_txn(OP_REG, 2'd2, 32'h0, 1'b0, 8'h07, '0, '0, '0));       // bad bus
      send_txn(make_txn(OP_REG, 2'd3, 32'h1, 1'b1, 8'h07, '0, '0, '0));
      send_txn(make_txn(OP_RECV, 2'd0, STD_MAX, 1'b0, '0, '0, '1, 4'hF));
      send_txn(make_txn(OP_RECV, 2'd1, EXT_MAX, 1'b1, '0, '0, 64'h0123_4567_89AB_CDEF,
                        4'h0));
      send_txn(make_txn(OP_RECV, 2'd1, STD_MAX, 1'b0, '0, '0, '1, 4'h8));     // miss
      send_txn(make_txn(OP_RECV, 2'd0, 32'hFFFF_FFFF, 1'b1, '0, '0, '1, 4'h8));
      send_txn(make_txn(OP_QUERY, 2'd1, EXT_MAX, 1'b1, '0, '0, '1, 4'hF));
      send_txn(make_txn(OP_QUERY, 2'd0, 32'h800, 1'b0, '0, '0, '0, '0));
      send_txn(make_txn(OP_LIST, 2'd0, '0, 1'b0, '0, 6'd0, '0, '0));
      send_txn(make_txn(OP_LIST, 2'd1, '0, 1'b0, '0, 6'd63, '0, '0));
      send_txn(make_txn(OP_LIST, 2'd2, '0, 1'b0, '0, 6'd32, '0, '0));
      send_txn(make_txn(OP_UNREG, 2'd0, STD_MAX, 1'b0, '0, '0, '0, '0));
      send_txn(make_txn(OP_UNREG, 2'd0, STD_MAX, 1'b0, '0, '0, '0, '0));      // gone
      send_txn(make_txn(OP_UNREG, 2'd1, EXT_MAX + 1, 1'b1, '0, '0, '0, '0));
      send_txn(make_txn(OP_SPARE_LO, '0, '0, 1'b0, '0, '0, '0, '0));
      send_txn(make_txn(OP_SPARE_HI, '1, '1, 1'b1, '1, '1, '1, '1));
   endtask

   // Fills every slot, overflows, lists the full table and reuses a freed slot
   task automatic test_full_table();
      logic [FRAME_W-1:0] id;
      logic               ext;
      int                 k;
      send_txn(make_txn(OP_CLEAR, '0, '0, 1'b0, '0, '0, '0, '0));
      for (int i = 0; i <= ENTRIES; i++) begin
         ext = 1'($urandom_range(0, 1));
         id  = ext ? (($urandom & EXT_MAX & ~32'h3F) | i)
                   : FRAME_W'(($urandom_range(0, 31) << 6) | i);
         send_txn(make_txn(OP_REG, BUS_W'($urandom_range(0, BUS_COUNT - 1)), id, ext,
                           TAG_W'($urandom_range(1, 255)), '0, '0, '0));
      end
      send_txn(make_txn(OP_LIST, 2'd0, '0, 1'b0, '0, 6'd63, '0, '0));
      send_txn(make_txn(OP_LIST, 2'd1, '0, 1'b0, '0, 6'd32, '0, '0));
      send_txn(make_txn(OP_LIST, 2'd0, '0, 1'b0, '0, 6'd3, '0, '0));
      // hold off until the table has answered everything, then free and refill
      drain_rsps();
      k = pick_live_slot();
      send_txn(make_txn(OP_UNREG, slot_bus[k], {3'b000, slot_ident[k]}, slot_ext[k],
                        '0, '0, '0, '0));
      send_txn(make_txn(OP_REG, 2'd1, 32'h7FE, 1'b0, 8'h80, '0, '0, '0));
      send_txn(make_txn(OP_REG, 2'd1, 32'h7FD, 1'b0, 8'h80, '0, '0, '0));
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < ITEMS; i++) begin
         steady = (i >= ITEMS / 3) && (i < ITEMS / 2);
         send_txn(make_random_txn());
      end
      steady = 1'b0;
   endtask

   initial begin
      empty_table();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_clear();
      test_directed();
      test_full_table();
      test_random_traffic();

      drain_rsps();
      repeat (TAIL_WAIT) @(posedge clock);
      if (awaited_rsps.size() != 0) begin
         $error("%0d results never arrived", awaited_rsps.size());
         fault_count++;
      end
      $display("tb: %0d transactions sent, %0d results checked", sent_count, checked_count);
      $display("tb: %0d matches, %0d lists, %0d full-table rejections",
               hit_count, list_count, full_count);
      if (fault_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

>>> can_id_dispatch_table.f
sv/cidt_pkg.sv
sv/cidt_front.sv
sv/cidt_queue.sv
sv/cidt_back.sv
sv/can_id_dispatch_table.sv
tb/sv/tb.sv
